@@ src/tcbd_pkg.sv @@
// Shared types and constants for the three-channel button dimmer.
// No dependencies; imported by every module of the block.
package tcbd_pkg;

  localparam int unsigned NUM_CH = 3;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] REG_LONG_PRESS    = 2'd0;
  localparam logic [1:0] REG_FAST_STEP     = 2'd1;
  localparam logic [1:0] REG_RAMP_FLOOR    = 2'd2;
  localparam logic [1:0] REG_RELAY_TIMEOUT = 2'd3;

  localparam logic [5:0] LONG_PRESS_RESET    = 6'd50;
  localparam logic [6:0] FAST_STEP_RESET     = 7'd9;
  localparam logic [7:0] RAMP_FLOOR_RESET    = 8'd13;
  localparam logic [7:0] RELAY_TIMEOUT_RESET = 8'd255;

  localparam logic [5:0] LONG_PRESS_MAX = 6'd62;
  localparam logic [5:0] SHORT_MIN      = 6'd2;
  localparam logic [7:0] LEVEL_FULL     = 8'd255;
  localparam logic [7:0] RAMP_TOP       = 8'd254;

  typedef enum logic [2:0] {
    INTENT_OFF        = 3'd0,
    INTENT_ON         = 3'd1,
    INTENT_UP         = 3'd2,
    INTENT_DOWN       = 3'd3,
    INTENT_STABLE_ON  = 3'd4,
    INTENT_STABLE_OFF = 3'd5,
    INTENT_EXT        = 3'd6
  } intent_t;

  typedef struct packed {
    logic [5:0] long_press;
    logic [6:0] fast_step;
    logic [7:0] ramp_floor;
  } lane_cfg_t;

  typedef struct packed {
    logic tick;
    logic write;
  } lane_ctl_t;

endpackage

@@ src/tcbd_lane.sv @@
// One dimmer channel: button scan, intent and level stepping.
// Depends on tcbd_pkg.
module tcbd_lane
  import tcbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lane_ctl_t  ctl,
  input  lane_cfg_t  cfg,
  input  logic       button,
  input  logic [7:0] target,
  output logic [7:0] level_next
);

  logic       prev;
  logic [5:0] hold;
  logic [7:0] level;
  intent_t    intent;
  logic       mark;
  logic [7:0] ext;

  logic       prev_next;
  logic [5:0] hold_next;
  intent_t    intent_next;
  logic       mark_next;
  logic [7:0] ext_next;

  always_comb begin
    logic [7:0] lv;
    logic [5:0] h;
    logic [8:0] sum;
    intent_t    in;
    logic       m;
    prev_next = prev;
    hold_next = hold;
    ext_next  = ext;
    lv        = level;
    in        = intent;
    m         = mark;
    h         = hold;
    sum       = 9'd0;
    if (ctl.write) begin
      ext_next = target;
      in       = (target == 8'd0) ? INTENT_OFF : INTENT_EXT;
    end else if (ctl.tick) begin
      if (button) begin
        if (prev) begin
          if (h < cfg.long_press) h = h + 6'd1;
          if (h == cfg.long_press) begin
            h = h + 6'd1;
            if (lv == 8'd0 || !m) begin
              m  = 1'b1;
              in = INTENT_UP;
            end else begin
              m  = 1'b0;
              in = INTENT_DOWN;
            end
          end
        end
      end else begin
        if (prev) begin
          if (h > SHORT_MIN && h < cfg.long_press) begin
            in = (lv == 8'd0) ? INTENT_ON : INTENT_OFF;
          end else if (h >= cfg.long_press) begin
            in = INTENT_STABLE_ON;
            if (lv < cfg.ramp_floor) lv = cfg.ramp_floor;
          end
        end
        h = 6'd0;
      end
      hold_next = h;
      prev_next = button;

      unique case (in)
        INTENT_ON: begin
          sum = {1'b0, lv} + {2'b00, cfg.fast_step};
          if (sum < {1'b0, LEVEL_FULL}) begin
            lv = sum[7:0];
          end else begin
            lv = LEVEL_FULL;
            in = INTENT_STABLE_ON;
          end
          m = 1'b1;
        end
        INTENT_OFF: begin
          if (lv > {1'b0, cfg.fast_step}) begin
            lv = lv - {1'b0, cfg.fast_step};
          end else begin
            lv = 8'd0;
            in = INTENT_STABLE_OFF;
          end
          m = 1'b0;
        end
        INTENT_UP: begin
          if (lv < RAMP_TOP) begin
            lv = lv + 8'd1;
          end else begin
            lv = LEVEL_FULL;
            in = INTENT_STABLE_ON;
          end
        end
        INTENT_DOWN: begin
          if ({1'b0, lv} > {1'b0, cfg.ramp_floor} + 9'd1) begin
            lv = lv - 8'd1;
          end else begin
            lv = cfg.ramp_floor;
            in = INTENT_STABLE_ON;
          end
        end
        INTENT_EXT: begin
          if (lv > ext) begin
            if (lv - ext > {1'b0, cfg.fast_step}) begin
              lv = lv - {1'b0, cfg.fast_step};
            end else begin
              lv = ext;
              in = INTENT_STABLE_ON;
            end
            m = 1'b0;
          end else if (lv < ext) begin
            if (ext - lv > {1'b0, cfg.fast_step}) begin
              lv = lv + {1'b0, cfg.fast_step};
            end else begin
              lv = ext;
              in = INTENT_STABLE_ON;
            end
            m = 1'b1;
          end else begin
            in = INTENT_STABLE_ON;
          end
        end
        default: begin
        end
      endcase
    end
    level_next  = lv;
    intent_next = in;
    mark_next   = m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev   <= 1'b0;
      hold   <= 6'd0;
      level  <= 8'd0;
      intent <= INTENT_OFF;
      mark   <= 1'b0;
      ext    <= 8'd0;
    end else begin
      prev   <= prev_next;
      hold   <= hold_next;
      level  <= level_next;
      intent <= intent_next;
      mark   <= mark_next;
      ext    <= ext_next;
    end
  end

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !prev |-> hold == 6'd0)
    else $error("hold count running with button released");

  a_write_keeps_level: assert property (@(posedge clk) disable iff (rst)
    ctl.write |=> $stable(level))
    else $error("level moved on a write word");

endmodule

@@ src/tcbd_relay.sv @@
// Merging stage: relay timer and relay drive from the lanes' new levels.
// Depends on tcbd_pkg.
module tcbd_relay
  import tcbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  logic       any_lit,
  input  logic [7:0] timeout,
  output logic       relay_next,
  output logic       relay_state
);

  logic [7:0] timer;
  logic [7:0] timer_inc;
  logic [7:0] timer_next;

  assign timer_inc = timer + 8'd1;

  always_comb begin
    timer_next = timer;
    relay_next = relay_state;
    if (tick) begin
      if (any_lit) begin
        timer_next = 8'd0;
        relay_next = 1'b1;
      end else begin
        timer_next = timer_inc;
        if (timer_inc == timeout) relay_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer       <= 8'd0;
      relay_state <= 1'b0;
    end else begin
      timer       <= timer_next;
      relay_state <= relay_next;
    end
  end

  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    !tick |=> $stable(timer) && $stable(relay_state))
    else $error("relay state moved without a tick");

  a_lit_energized: assert property (@(posedge clk) disable iff (rst)
    tick && any_lit |=> relay_state && timer == 8'd0)
    else $error("relay not energized while a channel is lit");

endmodule

@@ src/three_channel_button_dimmer.sv @@
// Top level of the three-channel button dimmer: lanes, relay merge, output word.
// Depends on tcbd_pkg, tcbd_lane and tcbd_relay.
//
//   channel | handshake           | payload
//   in      | in_valid / in_stall | opcode, buttons_pressed, target_level_0..2
//   out     | out_valid/out_stall | level_0..2, relay_on
//   cfg     | cfg_we              | cfg_index, cfg_data
//
// One word per cycle while in_stall is low; each word is done in the cycle it is
// accepted, and its result sits in the output register from the next cycle on.
// in_stall is high only while a result word waits under out_stall.
// Reset is synchronous and restores all channel state and register defaults.
module three_channel_button_dimmer
  import tcbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [2:0] buttons_pressed,
  input  logic [7:0] target_level_0,
  input  logic [7:0] target_level_1,
  input  logic [7:0] target_level_2,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] level_0,
  output logic [7:0] level_1,
  output logic [7:0] level_2,
  output logic       relay_on,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [5:0] long_press_ticks;
  logic [6:0] fast_step;
  logic [7:0] ramp_floor;
  logic [7:0] relay_timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks    <= LONG_PRESS_RESET;
      fast_step           <= FAST_STEP_RESET;
      ramp_floor          <= RAMP_FLOOR_RESET;
      relay_timeout_ticks <= RELAY_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG_PRESS:    long_press_ticks    <= cfg_data[5:0];
        REG_FAST_STEP:     fast_step           <= cfg_data[6:0];
        REG_RAMP_FLOOR:    ramp_floor          <= cfg_data;
        REG_RELAY_TIMEOUT: relay_timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic      in_acc;
  lane_ctl_t ctl;
  lane_cfg_t lane_cfg;

  assign in_stall  = out_valid && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign ctl.tick  = in_acc && (opcode == OP_TICK);
  assign ctl.write = in_acc && (opcode == OP_WRITE);

  assign lane_cfg.long_press = (long_press_ticks > LONG_PRESS_MAX) ? LONG_PRESS_MAX
                                                                   : long_press_ticks;
  assign lane_cfg.fast_step  = fast_step;
  assign lane_cfg.ramp_floor = ramp_floor;

  logic [7:0] targets [NUM_CH];
  logic [7:0] lvl_next [NUM_CH];
  logic       any_lit;
  logic       relay_next;
  logic       relay_state;

  assign targets[0] = target_level_0;
  assign targets[1] = target_level_1;
  assign targets[2] = target_level_2;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    tcbd_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cfg        (lane_cfg),
      .button     (buttons_pressed[c]),
      .target     (targets[c]),
      .level_next (lvl_next[c])
    );
  end

  assign any_lit = (lvl_next[0] != 8'd0) || (lvl_next[1] != 8'd0) || (lvl_next[2] != 8'd0);

  tcbd_relay u_relay (
    .clk         (clk),
    .rst         (rst),
    .tick        (ctl.tick),
    .any_lit     (any_lit),
    .timeout     (relay_timeout_ticks),
    .relay_next  (relay_next),
    .relay_state (relay_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      level_0  <= lvl_next[0];
      level_1  <= lvl_next[1];
      level_2  <= lvl_next[2];
      relay_on <= relay_next;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid && relay_on == relay_state)
    else $error("accepted word produced no matching result");

endmodule
